>>> rtl/complex_arithmetic_unit_core_defines.svh
// ============================================================================
// complex arithmetic unit - assertion macros
// shared concurrent check forms, clocked on clk and idle during reset
// ============================================================================
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CAU_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define CAU_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CAU_ASSERT_IMP(name, ante, cons)
`define CAU_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> rtl/cau_pkg.sv
// ============================================================================
// cau_pkg
// shared constants, codes and pipeline sideband types
// ============================================================================
package cau_pkg;

    localparam int CAU_FRAC_BITS = 16;
    localparam int CAU_QBITS     = 32;
    localparam int CAU_DW        = 64;
    localparam int CAU_LATENCY   = CAU_QBITS + 5;
    localparam logic [30:0] CAU_EPS_RESET = 31'd16;

    typedef enum logic [3:0] {
        MODE_ADD  = 4'd0,
        MODE_SUB  = 4'd1,
        MODE_MUL  = 4'd2,
        MODE_DIV  = 4'd3,
        MODE_NEG  = 4'd4,
        MODE_SQR  = 4'd5,
        MODE_INV  = 4'd6,
        MODE_EQ   = 4'd7,
        MODE_ZERO = 4'd8,
        MODE_MAG  = 4'd9
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        KIND_DIRECT,
        KIND_MUL,
        KIND_DIV,
        KIND_INV,
        KIND_ROOT
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        neg_re;
        logic        neg_im;
        logic [31:0] re;
        logic [31:0] im;
        logic        test;
        status_t     status;
    } side_t;

endpackage

>>> rtl/cau_divsqrt.sv
// ============================================================================
// cau_divsqrt
// pipelined restoring divider (two lanes, shared divisor) and square root,
// one quotient or root bit per stage
// ============================================================================
module cau_divsqrt #(
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  cau_pkg::side_t               in_side,
    input  logic [cau_pkg::CAU_DW-1:0]   n_re,
    input  logic [cau_pkg::CAU_DW-1:0]   n_im,
    input  logic [cau_pkg::CAU_DW-1:0]   d,
    output logic                         out_valid,
    output cau_pkg::side_t               out_side,
    output logic [cau_pkg::CAU_QBITS-1:0] q_re,
    output logic [cau_pkg::CAU_QBITS-1:0] q_im,
    output logic                         big_re,
    output logic                         big_im
);
    import cau_pkg::*;

    localparam int NW  = CAU_DW + 2 * FRAC_BITS;
    localparam int DQW = CAU_DW + CAU_QBITS;
    localparam int RW  = (NW > DQW) ? NW : DQW;
    localparam int QB  = CAU_QBITS;

    logic              valid_reg [0:QB];
    logic              valid_next [0:QB];
    side_t             side_reg [0:QB];
    side_t             side_next [0:QB];
    logic [RW-1:0]     rre_reg [0:QB];
    logic [RW-1:0]     rre_next [0:QB];
    logic [RW-1:0]     rim_reg [0:QB];
    logic [RW-1:0]     rim_next [0:QB];
    logic [QB-1:0]     qre_reg [0:QB];
    logic [QB-1:0]     qre_next [0:QB];
    logic [QB-1:0]     qim_reg [0:QB];
    logic [QB-1:0]     qim_next [0:QB];
    logic [CAU_DW-1:0] d_reg [0:QB];
    logic [CAU_DW-1:0] d_next [0:QB];
    logic              sq_reg [0:QB];
    logic              sq_next [0:QB];
    logic              bre_reg [0:QB];
    logic              bre_next [0:QB];
    logic              bim_reg [0:QB];
    logic              bim_next [0:QB];

    always_comb
    begin
        logic          dbl;
        logic          sq0;
        logic          isdiv;
        logic [RW-1:0] ext_re;
        logic [RW-1:0] ext_im;
        logic [RW-1:0] dq;
        logic [RW-1:0] t_re;
        logic [RW-1:0] t_im;
        logic          ge_re;
        logic          ge_im;
        int            k;

        // entry stage: align numerators, catch quotients that cannot fit
        dbl    = (in_side.kind == KIND_INV);
        sq0    = (in_side.kind == KIND_ROOT);
        isdiv  = (in_side.kind == KIND_DIV) || (in_side.kind == KIND_INV);
        ext_re = RW'(n_re);
        ext_im = RW'(n_im);
        dq     = RW'(d) << QB;

        valid_next[0] = in_valid;
        side_next[0]  = in_side;
        d_next[0]     = d;
        sq_next[0]    = sq0;
        qre_next[0]   = '0;
        qim_next[0]   = '0;
        if (sq0)
        begin
            rre_next[0] = ext_re;
        end
        else if (dbl)
        begin
            rre_next[0] = ext_re << (2 * FRAC_BITS);
        end
        else
        begin
            rre_next[0] = ext_re << FRAC_BITS;
        end
        if (dbl)
        begin
            rim_next[0] = ext_im << (2 * FRAC_BITS);
        end
        else
        begin
            rim_next[0] = ext_im << FRAC_BITS;
        end
        bre_next[0] = isdiv && (rre_next[0] >= dq);
        bim_next[0] = isdiv && (rim_next[0] >= dq);

        // one result bit per stage, msb first
        for (int j = 1; j <= QB; j++)
        begin
            k = QB - j;
            if (sq_reg[j-1])
            begin
                t_re = (RW'(qre_reg[j-1]) << (k + 1)) | (RW'(1) << (2 * k));
            end
            else
            begin
                t_re = RW'(d_reg[j-1]) << k;
            end
            t_im  = RW'(d_reg[j-1]) << k;
            ge_re = (rre_reg[j-1] >= t_re);
            ge_im = (rim_reg[j-1] >= t_im);

            rre_next[j]   = ge_re ? (rre_reg[j-1] - t_re) : rre_reg[j-1];
            rim_next[j]   = ge_im ? (rim_reg[j-1] - t_im) : rim_reg[j-1];
            qre_next[j]   = qre_reg[j-1] | (QB'(ge_re) << k);
            qim_next[j]   = qim_reg[j-1] | (QB'(ge_im) << k);
            valid_next[j] = valid_reg[j-1];
            side_next[j]  = side_reg[j-1];
            d_next[j]     = d_reg[j-1];
            sq_next[j]    = sq_reg[j-1];
            bre_next[j]   = bre_reg[j-1];
            bim_next[j]   = bim_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= QB; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else
        begin
            for (int j = 0; j <= QB; j++)
            begin
                valid_reg[j] <= valid_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= QB; j++)
        begin
            side_reg[j] <= side_next[j];
            rre_reg[j]  <= rre_next[j];
            rim_reg[j]  <= rim_next[j];
            qre_reg[j]  <= qre_next[j];
            qim_reg[j]  <= qim_next[j];
            d_reg[j]    <= d_next[j];
            sq_reg[j]   <= sq_next[j];
            bre_reg[j]  <= bre_next[j];
            bim_reg[j]  <= bim_next[j];
        end
    end

    assign out_valid = valid_reg[QB];
    assign out_side  = side_reg[QB];
    assign q_re      = qre_reg[QB];
    assign q_im      = qim_reg[QB];
    assign big_re    = bre_reg[QB];
    assign big_im    = bim_reg[QB];

endmodule

>>> rtl/complex_arithmetic_unit_core.sv
// ============================================================================
// complex_arithmetic_unit_core
// complex alu on signed fixed point operands: add, sub, mul, div, negate,
// square, invert, equal and zero tests, magnitude
// ============================================================================
// usage
//   request channel: drive mode and the four operand parts with start high;
//   a request is taken at every rising edge where start is high and busy is
//   low. busy never rises, so a new request can be taken every cycle.
//   result channel: done is high for exactly one cycle with res_real,
//   res_imag, test_true and status valid in that cycle. results come back
//   in request order. the receiver cannot hold results off and need not.
//   timing: every request takes the same path whatever the mode;
//   throughput is one request per cycle. the path is the 32-stage divider /
//   square root pipeline (one result bit per stage) plus input, multiply,
//   sum, entry and output register stages.
//   configuration: cfg_wen writes cfg_wdata into the epsilon register; write
//   it only while no request is in flight.
//   reset: rst_n clears every stage valid bit and done, epsilon returns to 16.
//   requests in flight at reset are dropped.
// ============================================================================
`include "complex_arithmetic_unit_core_defines.svh"

module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         mode,
    input  logic signed [31:0] a_real,
    input  logic signed [31:0] a_imag,
    input  logic signed [31:0] b_real,
    input  logic signed [31:0] b_imag,
    input  logic               cfg_wen,
    input  logic [30:0]        cfg_wdata,
    output logic               done,
    output logic signed [31:0] res_real,
    output logic signed [31:0] res_imag,
    output logic               test_true,
    output logic [1:0]         status
);
    import cau_pkg::*;

    // saturate a 33-bit exact sum to 32 bits, {overflow, value}
    function automatic logic [32:0] sat33(input logic [32:0] s);
        if (s[32] != s[31])
        begin
            return {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return {1'b0, s[31:0]};
    endfunction

    // saturate a sign and magnitude to 32 bits, {overflow, value}
    function automatic logic [32:0] sat64(input logic neg, input logic [63:0] m);
        if (!neg)
        begin
            if (m > 64'h0000_0000_7FFF_FFFF)
            begin
                return {1'b1, 32'h7FFF_FFFF};
            end
            return {1'b0, m[31:0]};
        end
        if (m > 64'h0000_0000_8000_0000)
        begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, 32'd0 - m[31:0]};
    endfunction

    // signed 66-bit view of a product magnitude
    function automatic logic [65:0] sval(input logic [63:0] p, input logic neg);
        return neg ? (66'd0 - {2'b00, p}) : {2'b00, p};
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [30:0] epsilon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= CAU_EPS_RESET;
        end
        else if (cfg_wen)
        begin
            epsilon_reg <= cfg_wdata;
        end
    end

    // always ready, the pipeline never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage a: request capture
    // ------------------------------------------------------------------
    logic        a_valid_reg;
    logic [3:0]  a_mode_reg;
    logic [31:0] a_ar_reg;
    logic [31:0] a_ai_reg;
    logic [31:0] a_br_reg;
    logic [31:0] a_bi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mode_reg <= mode;
        a_ar_reg   <= a_real;
        a_ai_reg   <= a_imag;
        a_br_reg   <= b_real;
        a_bi_reg   <= b_imag;
    end

    // ------------------------------------------------------------------
    // stage b: magnitudes, six 32x32 products, the simple modes
    // ------------------------------------------------------------------
    logic [31:0] mar;
    logic [31:0] mai;
    logic [31:0] myr;
    logic [31:0] myi;
    logic [31:0] yr;
    logic [31:0] yi;
    logic [31:0] u;
    logic [31:0] v;
    side_t       b_side_next;

    logic        b_valid_reg;
    side_t       b_side_reg;
    logic [63:0] b_prr_reg;
    logic [63:0] b_pii_reg;
    logic [63:0] b_pri_reg;
    logic [63:0] b_pir_reg;
    logic        b_nrr_reg;
    logic        b_nii_reg;
    logic        b_nri_reg;
    logic        b_nir_reg;
    logic [63:0] b_q1_reg;
    logic [63:0] b_q2_reg;
    logic [31:0] b_mar_reg;
    logic [31:0] b_mai_reg;
    logic        b_sar_reg;
    logic        b_sai_reg;

    always_comb
    begin
        mode_t       m;
        logic [32:0] sr;
        logic [32:0] si;
        logic [32:0] dr;
        logic [32:0] di;
        logic [32:0] adr;
        logic [32:0] adi;
        logic [32:0] rr;
        logic [32:0] ri;

        m = mode_t'(a_mode_reg);
        // squaring runs as a multiply of a by itself
        yr  = (m == MODE_SQR) ? a_ar_reg : a_br_reg;
        yi  = (m == MODE_SQR) ? a_ai_reg : a_bi_reg;
        mar = mag32(a_ar_reg);
        mai = mag32(a_ai_reg);
        myr = mag32(yr);
        myi = mag32(yi);
        // divide uses |b|^2, invert and magnitude use |a|^2
        u = (m == MODE_DIV) ? myr : mar;
        v = (m == MODE_DIV) ? myi : mai;

        sr  = {a_ar_reg[31], a_ar_reg} + {a_br_reg[31], a_br_reg};
        si  = {a_ai_reg[31], a_ai_reg} + {a_bi_reg[31], a_bi_reg};
        dr  = {a_ar_reg[31], a_ar_reg} - {a_br_reg[31], a_br_reg};
        di  = {a_ai_reg[31], a_ai_reg} - {a_bi_reg[31], a_bi_reg};
        adr = dr[32] ? (33'd0 - dr) : dr;
        adi = di[32] ? (33'd0 - di) : di;
        rr  = '0;
        ri  = '0;

        b_side_next        = '0;
        b_side_next.kind   = KIND_DIRECT;
        b_side_next.status = ST_OK;

        case (m)
            MODE_ADD:
            begin
                rr = sat33(sr);
                ri = sat33(si);
            end
            MODE_SUB:
            begin
                rr = sat33(dr);
                ri = sat33(di);
            end
            MODE_NEG:
            begin
                rr = sat33(33'd0 - {a_ar_reg[31], a_ar_reg});
                ri = sat33(33'd0 - {a_ai_reg[31], a_ai_reg});
            end
            MODE_EQ:
            begin
                b_side_next.test = (adr < {2'b00, epsilon_reg}) &&
                                   (adi < {2'b00, epsilon_reg});
            end
            MODE_ZERO:
            begin
                b_side_next.test = ({1'b0, mar} < {2'b00, epsilon_reg}) &&
                                   ({1'b0, mai} < {2'b00, epsilon_reg});
            end
            MODE_MUL, MODE_SQR:
            begin
                b_side_next.kind = KIND_MUL;
            end
            MODE_DIV:
            begin
                if (a_br_reg == '0 && a_bi_reg == '0)
                begin
                    b_side_next.status = ST_DIVZ;
                end
                else
                begin
                    b_side_next.kind = KIND_DIV;
                end
            end
            MODE_INV:
            begin
                if (a_ar_reg == '0 && a_ai_reg == '0)
                begin
                    b_side_next.status = ST_DIVZ;
                end
                else
                begin
                    b_side_next.kind = KIND_INV;
                end
            end
            MODE_MAG:
            begin
                b_side_next.kind = KIND_ROOT;
            end
            default:
            begin
                b_side_next.kind = KIND_DIRECT;
            end
        endcase

        b_side_next.re = rr[31:0];
        b_side_next.im = ri[31:0];
        if (rr[32] || ri[32])
        begin
            b_side_next.status = ST_OVF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_side_reg <= b_side_next;
        b_prr_reg  <= mar * myr;
        b_pii_reg  <= mai * myi;
        b_pri_reg  <= mar * myi;
        b_pir_reg  <= mai * myr;
        b_nrr_reg  <= a_ar_reg[31] ^ yr[31];
        b_nii_reg  <= a_ai_reg[31] ^ yi[31];
        b_nri_reg  <= a_ar_reg[31] ^ yi[31];
        b_nir_reg  <= a_ai_reg[31] ^ yr[31];
        b_q1_reg   <= u * u;
        b_q2_reg   <= v * v;
        b_mar_reg  <= mar;
        b_mai_reg  <= mai;
        b_sar_reg  <= a_ar_reg[31];
        b_sai_reg  <= a_ai_reg[31];
    end

    // ------------------------------------------------------------------
    // stage c: exact product sums, divisor, lane numerators
    // ------------------------------------------------------------------
    side_t       c_side_next;
    logic [63:0] c_nre_next;
    logic [63:0] c_nim_next;
    logic [63:0] c_d_next;

    logic        c_valid_reg;
    side_t       c_side_reg;
    logic [63:0] c_nre_reg;
    logic [63:0] c_nim_reg;
    logic [63:0] c_d_reg;

    always_comb
    begin
        logic        isdiv;
        logic [65:0] e_re;
        logic [65:0] e_im;
        logic [65:0] abs_re;
        logic [65:0] abs_im;

        // mul: rr - ii, ri + ir; div numerator: rr + ii, ir - ri
        isdiv  = (b_side_reg.kind == KIND_DIV);
        e_re   = sval(b_prr_reg, b_nrr_reg) + sval(b_pii_reg, b_nii_reg ^ !isdiv);
        e_im   = sval(b_pir_reg, b_nir_reg) + sval(b_pri_reg, b_nri_reg ^ isdiv);
        abs_re = e_re[65] ? (66'd0 - e_re) : e_re;
        abs_im = e_im[65] ? (66'd0 - e_im) : e_im;
        c_d_next    = b_q1_reg + b_q2_reg;
        c_side_next = b_side_reg;

        case (b_side_reg.kind)
            KIND_INV:
            begin
                // conj(a) over |a|^2
                c_nre_next         = {32'd0, b_mar_reg};
                c_nim_next         = {32'd0, b_mai_reg};
                c_side_next.neg_re = b_sar_reg;
                c_side_next.neg_im = !b_sai_reg;
            end
            KIND_ROOT:
            begin
                c_nre_next         = c_d_next;
                c_nim_next         = '0;
                c_side_next.neg_re = 1'b0;
                c_side_next.neg_im = 1'b0;
            end
            default:
            begin
                c_nre_next         = abs_re[63:0];
                c_nim_next         = abs_im[63:0];
                c_side_next.neg_re = e_re[65];
                c_side_next.neg_im = e_im[65];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_side_reg <= c_side_next;
        c_nre_reg  <= c_nre_next;
        c_nim_reg  <= c_nim_next;
        c_d_reg    <= c_d_next;
    end

    // ------------------------------------------------------------------
    // multiply results finish here, then every request goes through the divider
    // ------------------------------------------------------------------
    side_t ds_in_side;

    always_comb
    begin
        logic [32:0] mr;
        logic [32:0] mi;

        mr = sat64(c_side_reg.neg_re, c_nre_reg >> FRAC_BITS);
        mi = sat64(c_side_reg.neg_im, c_nim_reg >> FRAC_BITS);
        ds_in_side = c_side_reg;
        if (c_side_reg.kind == KIND_MUL)
        begin
            ds_in_side.re     = mr[31:0];
            ds_in_side.im     = mi[31:0];
            ds_in_side.status = (mr[32] || mi[32]) ? ST_OVF : ST_OK;
        end
    end

    logic                 ds_valid;
    side_t                ds_side;
    logic [CAU_QBITS-1:0] ds_qre;
    logic [CAU_QBITS-1:0] ds_qim;
    logic                 ds_bre;
    logic                 ds_bim;

    cau_divsqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divsqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_side   (ds_in_side),
        .n_re      (c_nre_reg),
        .n_im      (c_nim_reg),
        .d         (c_d_reg),
        .out_valid (ds_valid),
        .out_side  (ds_side),
        .q_re      (ds_qre),
        .q_im      (ds_qim),
        .big_re    (ds_bre),
        .big_im    (ds_bim)
    );

    // ------------------------------------------------------------------
    // output stage: saturate quotient or root, pick the result
    // ------------------------------------------------------------------
    logic        done_reg;
    logic [31:0] res_real_reg;
    logic [31:0] res_imag_reg;
    logic        test_reg;
    status_t     status_reg;
    logic [31:0] res_real_next;
    logic [31:0] res_imag_next;
    logic        test_next;
    status_t     status_next;

    always_comb
    begin
        logic [63:0] qr;
        logic [63:0] qi;
        logic [32:0] sr;
        logic [32:0] si;

        // a quotient too big for the pipeline saturates either way
        qr = ds_bre ? '1 : {32'd0, ds_qre};
        qi = ds_bim ? '1 : {32'd0, ds_qim};
        sr = '0;
        si = '0;

        case (ds_side.kind)
            KIND_DIV, KIND_INV:
            begin
                sr            = sat64(ds_side.neg_re, qr);
                si            = sat64(ds_side.neg_im, qi);
                res_real_next = sr[31:0];
                res_imag_next = si[31:0];
                test_next     = 1'b0;
                status_next   = (sr[32] || si[32]) ? ST_OVF : ST_OK;
            end
            KIND_ROOT:
            begin
                sr            = sat64(1'b0, qr);
                res_real_next = sr[31:0];
                res_imag_next = '0;
                test_next     = 1'b0;
                status_next   = sr[32] ? ST_OVF : ST_OK;
            end
            default:
            begin
                res_real_next = ds_side.re;
                res_imag_next = ds_side.im;
                test_next     = ds_side.test;
                status_next   = ds_side.status;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ds_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_real_reg <= res_real_next;
        res_imag_reg <= res_imag_next;
        test_reg     <= test_next;
        status_reg   <= status_next;
    end

    assign done      = done_reg;
    assign res_real  = res_real_reg;
    assign res_imag  = res_imag_reg;
    assign test_true = test_reg;
    assign status    = status_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // every result traces back to a request exactly one latency earlier
    `CAU_ASSERT_IMP(a_done_latency, done, $past(start && !busy, CAU_LATENCY))
    // a zero divisor never leaks a quotient
    `CAU_ASSERT_IMP(a_divz_zero, done && status == ST_DIVZ, res_real == '0 && res_imag == '0 && !test_true)
    // a true test comes with clean zero parts
    `CAU_ASSERT_IMP(a_test_clean, done && test_true, status == ST_OK && res_real == '0 && res_imag == '0)
    // a magnitude is never negative and has no imaginary part
    `CAU_ASSERT_NXT(a_root_pos, ds_valid && ds_side.kind == KIND_ROOT, !res_real[31] && res_imag == '0)

endmodule

>>> tb/sv/complex_arithmetic_unit_core_test.sv
// ============================================================================
// complex_arithmetic_unit_core_test
// self-checking bench for the complex alu: a queue-fed driver sends requests,
// a bit-exact predictor computes each result at acceptance, and a monitor
// compares every done strobe against the oldest prediction
// ============================================================================
module complex_arithmetic_unit_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cau_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM       = 120;
    localparam logic signed [127:0] FRAC_SCALE = 128'sd1 <<< CAU_FRAC_BITS;
    localparam logic signed [127:0] POS_LIMIT  = 128'sd2147483647;
    localparam logic signed [127:0] NEG_LIMIT  = -128'sd2147483648;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } request_t;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        tt;
        logic [1:0]  st;
    } result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [3:0]         mode = '0;
    logic signed [31:0] a_real = '0;
    logic signed [31:0] a_imag = '0;
    logic signed [31:0] b_real = '0;
    logic signed [31:0] b_imag = '0;
    logic               cfg_wen = 1'b0;
    logic [30:0]        cfg_wdata = '0;
    logic               done;
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               test_true;
    logic [1:0]         status;

    request_t pending_reqs[$];     // requests waiting to be sent
    result_t  expected_results[$]; // predictions waiting for a done strobe
    request_t drv_req = '0;        // request currently on the ports
    logic [30:0] epsilon_model = CAU_EPS_RESET;
    int idle_pct = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_flagged = 0;             // results with nonzero status or test true
    int stall_cycles = 0;

    complex_arithmetic_unit_core i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata), .done(done),
        .res_real(res_real), .res_imag(res_imag), .test_true(test_true),
        .status(status)
    );

    always #6 clk = ~clk;

    // clamp a wide exact value into 32 bits, noting any overflow
    function automatic logic [31:0] saturate(input logic signed [127:0] v, inout logic ovf);
        if (v > POS_LIMIT)
        begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < NEG_LIMIT)
        begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // floor square root, one result bit per step
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] b;
        root = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [127:0] magnitude(input logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // exact math in 128 bits; signed division truncates toward zero
    function automatic result_t alu_result(input request_t r);
        logic signed [127:0] ar, ai, br, bi, den, eps;
        logic ovf;
        result_t o;
        ar = r.a_real;
        ai = r.a_imag;
        br = r.b_real;
        bi = r.b_imag;
        eps = $signed({97'd0, epsilon_model});
        ovf = 1'b0;
        o = '0;
        o.st = ST_OK;
        case (r.mode)
            MODE_ADD:
            begin
                o.re = saturate(ar + br, ovf);
                o.im = saturate(ai + bi, ovf);
            end
            MODE_SUB:
            begin
                o.re = saturate(ar - br, ovf);
                o.im = saturate(ai - bi, ovf);
            end
            MODE_MUL:
            begin
                o.re = saturate((ar * br - ai * bi) / FRAC_SCALE, ovf);
                o.im = saturate((ar * bi + ai * br) / FRAC_SCALE, ovf);
            end
            MODE_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    o.st = ST_DIVZ;
                else
                begin
                    o.re = saturate((ar * br + ai * bi) * FRAC_SCALE / den, ovf);
                    o.im = saturate((ai * br - ar * bi) * FRAC_SCALE / den, ovf);
                end
            end
            MODE_NEG:
            begin
                o.re = saturate(-ar, ovf);
                o.im = saturate(-ai, ovf);
            end
            MODE_SQR:
            begin
                o.re = saturate((ar * ar - ai * ai) / FRAC_SCALE, ovf);
                o.im = saturate((2 * ar * ai) / FRAC_SCALE, ovf);
            end
            MODE_INV:
            begin
                den = ar * ar + ai * ai;
                if (den == 0)
                    o.st = ST_DIVZ;
                else
                begin
                    o.re = saturate(ar * FRAC_SCALE * FRAC_SCALE / den, ovf);
                    o.im = saturate(-ai * FRAC_SCALE * FRAC_SCALE / den, ovf);
                end
            end
            MODE_EQ:
                o.tt = (magnitude(ar - br) < eps) && (magnitude(ai - bi) < eps);
            MODE_ZERO:
                o.tt = (magnitude(ar) < eps) && (magnitude(ai) < eps);
            MODE_MAG:
                o.re = saturate($signed({64'd0, int_sqrt(64'(ar * ar + ai * ai))}), ovf);
            default:
                ; // unused codes give all zeros
        endcase
        if (ovf && o.st == ST_OK)
            o.st = ST_OVF;
        return o;
    endfunction

    // driver: a slot is free unless a request is held off by busy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(alu_result(drv_req));
                n_requests++;
            end
            if (!(start && busy))
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    drv_req <= pending_reqs[0];
                    mode    <= pending_reqs[0].mode;
                    a_real  <= pending_reqs[0].a_real;
                    a_imag  <= pending_reqs[0].a_imag;
                    b_real  <= pending_reqs[0].b_real;
                    b_imag  <= pending_reqs[0].b_imag;
                    void'(pending_reqs.pop_front());
                    start   <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: each done strobe is checked against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result re=%h im=%h test=%b status=%0d",
                             res_real, res_imag, test_true, status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.st != ST_OK || want.tt)
                    n_flagged++;
                if (res_real !== want.re || res_imag !== want.im ||
                    test_true !== want.tt || status !== want.st)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp re=%h im=%h test=%b status=%0d, got re=%h im=%h test=%b status=%0d",
                                 want.re, want.im, want.tt, want.st,
                                 res_real, res_imag, test_true, status);
                end
            end
        end
    end

    // watchdog: too long with no request or result accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding",
                         expected_results.size());
                $display("Simulation FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic signed [31:0] rand_part();
        case ($urandom_range(5))
            0: return $signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
            1: return $signed($urandom_range(32'h03FF_FFFF)) - 32'sh0200_0000;
            2: return $signed($urandom_range(16)) <<< CAU_FRAC_BITS;
            3:
            begin
                case ($urandom_range(3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic request_t rand_request();
        request_t r;
        r.mode   = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                             : 4'($urandom_range(MODE_MAG));
        r.a_real = rand_part();
        r.a_imag = rand_part();
        r.b_real = rand_part();
        r.b_imag = rand_part();
        // equality tests mostly with B close to A
        if (r.mode == MODE_EQ && $urandom_range(3) != 0)
        begin
            r.b_real = r.a_real + $signed($urandom_range(64)) - 32;
            r.b_imag = r.a_imag + $signed($urandom_range(64)) - 32;
        end
        if (r.mode == MODE_DIV && $urandom_range(7) == 0)
        begin
            r.b_real = '0;
            r.b_imag = '0;
        end
        if (r.mode == MODE_INV && $urandom_range(7) == 0)
        begin
            r.a_real = '0;
            r.a_imag = '0;
        end
        return r;
    endfunction

    function automatic request_t make_req(input logic [3:0] m,
                                          input logic signed [31:0] ar, ai, br, bi);
        request_t r;
        r.mode = m;
        r.a_real = ar;
        r.a_imag = ai;
        r.b_real = br;
        r.b_imag = bi;
        return r;
    endfunction

    // wait for every request sent and every result back, plus pipeline depth
    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (CAU_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_epsilon(input logic [30:0] v);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        epsilon_model = v;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        repeat (n) pending_reqs.push_back(rand_request());
    endtask

    localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every mode, divide by zero, saturation, tests
        pending_reqs.push_back(make_req(MODE_ADD, PMAX, PMIN, PMAX, PMIN));
        pending_reqs.push_back(make_req(MODE_ADD, ONE, -ONE, 32'sd5, -32'sd7));
        pending_reqs.push_back(make_req(MODE_SUB, PMIN, PMAX, ONE, -ONE));
        pending_reqs.push_back(make_req(MODE_SUB, 32'sd3, 32'sd3, 32'sd3, 32'sd3));
        pending_reqs.push_back(make_req(MODE_MUL, 2 * ONE, 3 * ONE, -ONE, 4 * ONE));
        pending_reqs.push_back(make_req(MODE_MUL, PMAX, PMIN, PMAX, PMIN));
        pending_reqs.push_back(make_req(MODE_DIV, ONE, ONE, 32'sd0, 32'sd0));
        pending_reqs.push_back(make_req(MODE_DIV, 3 * ONE, -ONE, ONE, 2 * ONE));
        pending_reqs.push_back(make_req(MODE_DIV, PMAX, PMAX, 32'sd1, 32'sd0));
        pending_reqs.push_back(make_req(MODE_NEG, PMIN, PMAX, 32'sd0, 32'sd0));
        pending_reqs.push_back(make_req(MODE_SQR, 3 * ONE, -2 * ONE, 32'sd0, 32'sd0));
        pending_reqs.push_back(make_req(MODE_SQR, PMIN, PMIN, 32'sd0, 32'sd0));
        pending_reqs.push_back(make_req(MODE_INV, 32'sd0, 32'sd0, ONE, ONE));
        pending_reqs.push_back(make_req(MODE_INV, ONE, ONE, 32'sd0, 32'sd0));
        pending_reqs.push_back(make_req(MODE_INV, 32'sd1, 32'sd0, 32'sd0, 32'sd0));
        pending_reqs.push_back(make_req(MODE_EQ, ONE, ONE, ONE + 15, ONE - 15));
        pending_reqs.push_back(make_req(MODE_EQ, ONE, ONE, ONE + 16, ONE));
        pending_reqs.push_back(make_req(MODE_EQ, PMAX, PMIN, PMIN, PMAX));
        pending_reqs.push_back(make_req(MODE_ZERO, 32'sd15, -32'sd15, PMAX, PMIN));
        pending_reqs.push_back(make_req(MODE_ZERO, -32'sd16, 32'sd0, 32'sd0, 32'sd0));
        pending_reqs.push_back(make_req(MODE_MAG, 3 * ONE, -4 * ONE, 32'sd0, 32'sd0));
        pending_reqs.push_back(make_req(MODE_MAG, PMIN, PMIN, 32'sd0, 32'sd0));
        pending_reqs.push_back(make_req(4'd10, ONE, ONE, ONE, ONE));
        pending_reqs.push_back(make_req(4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
        drain();

        // epsilon at zero: tests can never pass; back-to-back requests
        write_epsilon('0);
        idle_pct = 0;
        queue_random(N_RANDOM);
        drain();

        // epsilon at its maximum with a mostly idle sender
        write_epsilon(31'h7FFF_FFFF);
        idle_pct = 83;
        queue_random(N_RANDOM);
        drain();

        // random epsilon with light idling
        write_epsilon(31'($urandom_range(256)));
        idle_pct = 13;
        queue_random(N_RANDOM);
        drain();

        // reset value again, mixed idling
        write_epsilon(CAU_EPS_RESET);
        idle_pct = 40;
        queue_random(N_RANDOM);
        drain();

        $display("covered %0d requests over four epsilon settings and idle rates 0/13/40/83%%",
                 n_requests);
        $display("%0d results checked, %0d flagged or test-true, %0d mismatches",
                 n_results, n_flagged, n_mismatch);
        if (n_mismatch == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
